[rtl/rc_frame_check_channel_unpack_unit_assert.svh]
// Assertion macros shared by the frame check checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef RC_FRAME_CHECK_CHANNEL_UNPACK_UNIT_ASSERT_SVH
`define RC_FRAME_CHECK_CHANNEL_UNPACK_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define RCFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rcfc assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define RCFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rcfc assertion failed");

`endif

[rtl/rcfc_pkg.sv]
// Shared constants, codes and the CRC table function of the frame check block.
// No dependencies; imported by the top level and the checker.
package rcfc_pkg;

  // Frame geometry.
  localparam logic [5:0] FrameLenShort = 6'd32;
  localparam logic [5:0] FrameLenLong  = 6'd35;
  localparam int unsigned WordsPerFrameDefault = 8;
  localparam int unsigned ChanBytes = 12;

  // Header positions.
  localparam logic [5:0] PosLength   = 6'd0;
  localparam logic [5:0] PosIdHigh   = 6'd1;
  localparam logic [5:0] PosIdLow    = 6'd2;
  localparam logic [5:0] PosCrcFirst = 6'd3;
  localparam logic [5:0] PosRxNum    = 6'd6;
  localparam logic [5:0] PosFlag     = 6'd7;
  localparam logic [5:0] PosChanFirst = 6'd9;
  localparam logic [5:0] PosChanLast  = 6'd20;

  // Channel word decoding.
  localparam logic [7:0]  SkipBase    = 8'h10;
  localparam logic [11:0] ValueOffset = 12'd64;
  localparam logic [15:0] CrcPolyRefl = 16'h8408;

  // Configuration register indexes.
  localparam logic [1:0] CfgLongMode = 2'd0;
  localparam logic [1:0] CfgBoundId  = 2'd1;
  localparam logic [1:0] CfgBoundRx  = 2'd2;

  // Verdict codes.
  localparam logic [1:0] VerdictAccept = 2'd0;
  localparam logic [1:0] VerdictCrcErr = 2'd1;
  localparam logic [1:0] VerdictHdrErr = 2'd2;

  // Result kinds.
  localparam logic KindVerdict = 1'b0;
  localparam logic KindChannel = 1'b1;

  // One entry of the reflected 0x8408 table (entry 1 is 0x1189).
  function automatic logic [15:0] crc_table(input logic [7:0] idx);
    logic [15:0] c;
    c = {8'h00, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPolyRefl) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/rc_frame_check_channel_unpack_unit.sv]
// Radio frame check and channel unpack: the top level and only RTL module.
// Depends on rcfc_pkg.
//
// Usage:
// Frame bytes enter on the s_axis channel, one per beat; s_axis_tuser[0] marks
// the first byte of a frame and restarts any partial frame. Frames are 32 bytes
// (long_frame_mode 0) or 35 bytes (long_frame_mode 1). The cfg channel writes
// the mode, the bound transmitter id and the bound receiver number; cfg_ready_o
// is always high. While a frame streams in, one byte is taken per cycle and the
// CRC is updated in the same cycle. The last byte of a frame loads a verdict
// beat into the output register. An accepted frame then yields up to
// WORDS_PER_FRAME channel beats; each beat passes through S_ADDR, which reads
// the 12-entry channel byte memory, and S_DATA, which loads the output
// register once it is free; while these beats are produced, s_axis_tready
// is low. m_axis_tlast marks the final beat of a frame. When the receiver
// stalls, the output register holds its beat; bytes of the next frame are still
// taken, except the last one, which waits until the register is free.
// Reset clears the frame position, CRC, configuration and output valid flag;
// the channel byte memory needs no clearing: each entry is written before a read.
module rc_frame_check_channel_unpack_unit #(
  parameter int unsigned WORDS_PER_FRAME = rcfc_pkg::WordsPerFrameDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Frame byte input.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  logic [0:0]  s_axis_tuser,   // [0] frame_start
  // Result output.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [1:0] verdict, [5:2] channel_slot,
                                      // [17:6] channel_value, [23:18] zero
  output logic [0:0]  m_axis_tuser,   // [0] result_kind
  output logic        m_axis_tlast    // last_of_frame
);
  import rcfc_pkg::*;

  localparam int unsigned IdxW = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(WORDS_PER_FRAME - 1);

  typedef enum logic [1:0] {
    S_RUN,
    S_ADDR,
    S_DATA
  } state_e;

  // Configuration registers.
  logic        long_mode_q;
  logic [15:0] bound_id_q;
  logic [7:0]  bound_rx_q;

  // Frame state.
  state_e          state_q, state_d;
  logic [5:0]      pos_q, pos_d;
  logic [15:0]     crc_q, crc_d;
  logic [15:0]     rx_crc_q, rx_crc_d;
  logic            hdr_ok_q, hdr_ok_d;
  logic [7:0]      flag_q, flag_d;
  logic [IdxW-1:0] idx_q, idx_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic        out_kind_q, out_kind_d;
  logic [1:0]  out_verdict_q, out_verdict_d;
  logic [3:0]  out_slot_q, out_slot_d;
  logic [11:0] out_value_q, out_value_d;
  logic        out_last_q, out_last_d;

  // Channel byte memory.
  logic [7:0] chan_mem [ChanBytes];
  logic [7:0] rd0_q, rd1_q;
  logic [3:0] rd0_addr, rd1_addr;
  logic [3:0] wr_addr;
  logic       wr_en;

  logic [5:0]  frame_len;
  logic        in_fire;
  logic        out_free;
  logic [5:0]  pos_cur;
  logic        frame_clear;
  logic [15:0] crc_cur;
  logic        hdr_cur;
  logic        pos_at_last;
  logic [IdxW-1:0] last_idx;
  logic        any_word;
  logic        idx_skip;
  logic [3:0]  k3;
  logic [11:0] word;

  assign frame_len   = long_mode_q ? FrameLenLong : FrameLenShort;
  assign pos_at_last = (pos_q == frame_len - 6'd1);
  assign s_axis_tready = (state_q == S_RUN) && (!out_valid_q || !pos_at_last);
  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign out_free    = !out_valid_q || m_axis_tready;
  assign cfg_ready_o = 1'b1;

  // Register writes on the configuration channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_mode_q <= 1'b0;
      bound_id_q  <= '0;
      bound_rx_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgLongMode: long_mode_q <= cfg_data_i[0];
        CfgBoundId:  bound_id_q  <= cfg_data_i;
        CfgBoundRx:  bound_rx_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Skip tests on the stored flag byte: at most one word can match it.
  function automatic logic is_skipped(input logic [7:0] flag, input logic [IdxW-1:0] i);
    return flag == (SkipBase + {3'b000, 4'(i), 1'b0});
  endfunction

  always_comb begin
    last_idx = IdxLast;
    any_word = 1'b1;
    if (is_skipped(flag_q, IdxLast)) begin
      if (WORDS_PER_FRAME > 1) begin
        last_idx = IdxLast - IdxW'(1);
      end else begin
        any_word = 1'b0;
      end
    end
  end
  assign idx_skip = is_skipped(flag_q, idx_q);

  // Memory read addresses of word idx_q, and the assembled word.
  assign k3 = (4'(idx_q >> 1) << 1) + 4'(idx_q >> 1);
  assign rd0_addr = idx_q[0] ? k3 + 4'd1 : k3;
  assign rd1_addr = idx_q[0] ? k3 + 4'd2 : k3 + 4'd1;
  assign word = idx_q[0] ? {rd1_q, rd0_q[7:4]} : {rd1_q[3:0], rd0_q};

  // Current frame position after a restart by the start flag or a mode change.
  assign frame_clear = s_axis_tuser[0] || (pos_q >= frame_len);
  assign pos_cur     = frame_clear ? 6'd0 : pos_q;
  assign crc_cur     = frame_clear ? 16'h0000 : crc_q;
  assign hdr_cur     = frame_clear ? 1'b1 : hdr_ok_q;

  // Channel bytes are stored as they stream past.
  assign wr_en   = in_fire && (pos_cur >= PosChanFirst) && (pos_cur <= PosChanLast);
  assign wr_addr = 4'(pos_cur - PosChanFirst);

  // Next state of the frame tracker, the word sequencer and the output register.
  always_comb begin
    logic [7:0] b;
    logic [1:0] verdict;
    b = s_axis_tdata;
    verdict = VerdictAccept;

    state_d       = state_q;
    pos_d         = pos_q;
    crc_d         = crc_q;
    rx_crc_d      = rx_crc_q;
    hdr_ok_d      = hdr_ok_q;
    flag_d        = flag_q;
    idx_d         = idx_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_kind_d    = out_kind_q;
    out_verdict_d = out_verdict_q;
    out_slot_d    = out_slot_q;
    out_value_d   = out_value_q;
    out_last_d    = out_last_q;

    unique case (state_q)
      S_RUN: begin
        if (in_fire) begin
          crc_d    = crc_cur;
          hdr_ok_d = hdr_cur;
          if (frame_clear) begin
            rx_crc_d = '0;
          end
          if ((pos_cur == PosLength) && (b != 8'(frame_len - 6'd3))) hdr_ok_d = 1'b0;
          if ((pos_cur == PosIdHigh) && (b != bound_id_q[15:8]))     hdr_ok_d = 1'b0;
          if ((pos_cur == PosIdLow) && (b != bound_id_q[7:0]))       hdr_ok_d = 1'b0;
          if ((pos_cur == PosRxNum) && (b != 8'd0) && (bound_rx_q != 8'd0)
              && (b != bound_rx_q)) begin
            hdr_ok_d = 1'b0;
          end
          if (pos_cur == PosFlag) flag_d = b;
          if ((pos_cur >= PosCrcFirst) && (pos_cur <= frame_len - 6'd5)) begin
            crc_d = {crc_cur[7:0], 8'h00} ^ crc_table(crc_cur[15:8] ^ b);
          end
          if (pos_cur == frame_len - 6'd4) rx_crc_d[15:8] = b;
          if (pos_cur == frame_len - 6'd3) rx_crc_d[7:0]  = b;

          if (pos_cur == frame_len - 6'd1) begin
            // Frame end: load the verdict and start the word sequencer.
            if (crc_cur != rx_crc_q) begin
              verdict = VerdictCrcErr;
            end else if (!hdr_cur) begin
              verdict = VerdictHdrErr;
            end
            out_valid_d   = 1'b1;
            out_kind_d    = KindVerdict;
            out_verdict_d = verdict;
            out_slot_d    = '0;
            out_value_d   = '0;
            out_last_d    = (verdict != VerdictAccept) || !any_word;
            pos_d    = '0;
            crc_d    = '0;
            rx_crc_d = '0;
            hdr_ok_d = 1'b1;
            idx_d    = '0;
            if ((verdict == VerdictAccept) && any_word) begin
              state_d = S_ADDR;
            end
          end else begin
            pos_d = pos_cur + 6'd1;
          end
        end
      end
      S_ADDR: begin
        // The memory reads word idx_q at this edge; skipped words are passed over.
        if (idx_skip) begin
          idx_d = idx_q + IdxW'(1);
        end else begin
          state_d = S_DATA;
        end
      end
      S_DATA: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_kind_d    = KindChannel;
          out_verdict_d = VerdictAccept;
          out_slot_d    = 4'(idx_q) + (word[11] ? 4'd8 : 4'd0);
          out_value_d   = {1'b0, word[10:0]} - ValueOffset;
          out_last_d    = (idx_q == last_idx);
          if (idx_q == last_idx) begin
            state_d = S_RUN;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = S_ADDR;
          end
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  // State, frame registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      pos_q       <= '0;
      crc_q       <= '0;
      rx_crc_q    <= '0;
      hdr_ok_q    <= 1'b1;
      flag_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      rx_crc_q    <= rx_crc_d;
      hdr_ok_q    <= hdr_ok_d;
      flag_q      <= flag_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q    <= out_kind_d;
    out_verdict_q <= out_verdict_d;
    out_slot_q    <= out_slot_d;
    out_value_q   <= out_value_d;
    out_last_q    <= out_last_d;
  end

  // Channel byte memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      chan_mem[wr_addr] <= b_in_byte();
    end
    rd0_q <= chan_mem[rd0_addr];
    rd1_q <= chan_mem[rd1_addr];
  end

  function automatic logic [7:0] b_in_byte();
    return s_axis_tdata;
  endfunction

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, out_value_q, out_slot_q, out_verdict_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[rtl/rcfc_checker.sv]
// Port-level checker for the frame check block, bound to its top level.
// Depends on rcfc_pkg and rc_frame_check_channel_unpack_unit_assert.svh.
`include "rc_frame_check_channel_unpack_unit_assert.svh"

module rcfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_index_i,
  input logic [15:0] cfg_data_i,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input logic [0:0]  s_axis_tuser,   // [0] frame_start
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,   // [1:0] verdict, [5:2] slot, [17:6] value
  input logic [0:0]  m_axis_tuser,   // [0] result_kind
  input logic        m_axis_tlast
);
  import rcfc_pkg::*;

  // A stalled beat keeps its contents.
  `RCFC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // While a frame still has results to come, no byte is taken.
  `RCFC_ASSERT_NOW(a_no_input_mid_results, m_axis_tvalid && !m_axis_tlast,
    !s_axis_tready)

  // A rejected frame ends with its verdict.
  `RCFC_ASSERT_NOW(a_reject_is_last,
    m_axis_tvalid && (m_axis_tuser[0] == KindVerdict)
    && (m_axis_tdata[1:0] != VerdictAccept), m_axis_tlast)

  // Channel beats carry an accept code.
  `RCFC_ASSERT_NOW(a_channel_verdict, m_axis_tvalid && (m_axis_tuser[0] == KindChannel),
    m_axis_tdata[1:0] == VerdictAccept)

  // The verdict code is never the unused one.
  `RCFC_ASSERT_NOW(a_verdict_code, m_axis_tvalid,
    (m_axis_tdata[1:0] == VerdictAccept) || (m_axis_tdata[1:0] == VerdictCrcErr)
    || (m_axis_tdata[1:0] == VerdictHdrErr))

endmodule

bind rc_frame_check_channel_unpack_unit rcfc_checker u_rcfc_checker (.*);

[bench/rc_frame_check_channel_unpack_unit_tb.sv]
// Self-checking bench for the radio frame check and channel unpack block.
// Depends on rcfc_pkg and rc_frame_check_channel_unpack_unit; a scoreboard class
// predicts verdict and channel beats from the accepted frame bytes.
`timescale 1ns / 1ps

module rc_frame_check_channel_unpack_unit_tb;
  import rcfc_pkg::*;

  localparam int Words        = WordsPerFrameDefault;
  localparam int ItemTarget   = 120;
  localparam int ResultTarget = 100;
  localparam int LongStall    = 300;
  localparam int IdleLimit    = 3000;
  localparam int DrainCycles  = 40;
  localparam int MaxReports   = 10;

  // One result beat as the block presents it, split into its fields.
  typedef struct packed {
    logic        kind;
    logic [1:0]  verdict;
    logic [3:0]  slot;
    logic [11:0] value;
    logic        last;
  } result_beat_t;

  // Ways the stimulus can spoil a frame.
  typedef enum int {
    FaultNone, FaultCrc, FaultLen, FaultId, FaultRx, FaultBoth, FaultJunk
  } frame_fault_e;

  // Frame tracker: mirrors the block state and queues the beats each byte causes.
  class frame_scoreboard;
    logic         long_mode;
    logic [15:0]  bound_id;
    logic [7:0]   bound_rx;
    logic [5:0]   pos;
    logic [15:0]  crc_run;
    logic [15:0]  crc_rx;
    logic         hdr_ok;
    logic [7:0]   flag;
    logic [7:0]   chan [ChanBytes];
    logic [15:0]  crc_lut [256];
    result_beat_t pending_q [$];
    int errors;
    int n_frames;
    int n_accept;
    int n_crc_bad;
    int n_hdr_bad;
    int n_updates;
    int n_writes;
    int n_planned;

    function new();
      logic [15:0] c;
      // Table of the reflected polynomial, built bit by bit.
      for (int n = 0; n < 256; n++) begin
        c = 16'(n);
        for (int k = 0; k < 8; k++) begin
          c = c[0] ? ((c >> 1) ^ CrcPolyRefl) : (c >> 1);
        end
        crc_lut[n] = c;
      end
      long_mode = 1'b0;
      bound_id  = 16'h0000;
      bound_rx  = 8'h00;
      flag      = 8'h00;
      for (int n = 0; n < ChanBytes; n++) chan[n] = 8'h00;
      clear_frame();
    endfunction

    function void clear_frame();
      pos     = 6'd0;
      crc_run = 16'h0000;
      crc_rx  = 16'h0000;
      hdr_ok  = 1'b1;
    endfunction

    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      return (c << 8) ^ crc_lut[c[15:8] ^ b];
    endfunction

    // Twelve-bit word i out of the stored channel bytes.
    function logic [11:0] chan_word(int i);
      int k;
      k = (i / 2) * 3;
      if (i % 2 == 0) return {chan[k + 1][3:0], chan[k]};
      return {chan[k + 2], chan[k + 1][7:4]};
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      n_writes++;
      case (idx)
        CfgLongMode: long_mode = data[0];
        CfgBoundId:  bound_id  = data;
        CfgBoundRx:  bound_rx  = data[7:0];
        default: ;
      endcase
    endfunction

    // Take one accepted frame byte; a frame end queues the verdict and updates.
    function void note_frame_byte(logic [7:0] b, logic start);
      logic [5:0]   flen;
      logic [5:0]   p;
      logic [1:0]   verdict;
      logic [11:0]  w;
      result_beat_t beat;
      int           live [$];
      flen = long_mode ? FrameLenLong : FrameLenShort;
      if (start || pos >= flen) clear_frame();
      p = pos;

      // Header fields.
      if (p == PosLength && b != {2'b00, flen - 6'd3}) hdr_ok = 1'b0;
      if (p == PosIdHigh && b != bound_id[15:8]) hdr_ok = 1'b0;
      if (p == PosIdLow && b != bound_id[7:0]) hdr_ok = 1'b0;
      if (p == PosRxNum && !(b == 8'h00 || bound_rx == 8'h00 || b == bound_rx)) hdr_ok = 1'b0;
      if (p == PosFlag) flag = b;
      if (p >= PosChanFirst && p <= PosChanLast) chan[p - PosChanFirst] = b;

      // Running and stored checksum.
      if (p >= PosCrcFirst && p <= flen - 6'd5) crc_run = crc_step(crc_run, b);
      if (p == flen - 6'd4) crc_rx[15:8] = b;
      if (p == flen - 6'd3) crc_rx[7:0] = b;

      if (p != flen - 6'd1) begin
        pos = p + 6'd1;
        return;
      end

      // Frame end: checksum failure outranks a header failure.
      if (crc_run != crc_rx) verdict = VerdictCrcErr;
      else if (!hdr_ok) verdict = VerdictHdrErr;
      else verdict = VerdictAccept;
      n_frames++;
      case (verdict)
        VerdictAccept: n_accept++;
        VerdictCrcErr: n_crc_bad++;
        default:       n_hdr_bad++;
      endcase

      if (verdict == VerdictAccept) begin
        for (int i = 0; i < Words; i++) begin
          if (flag != SkipBase + 8'(2 * i)) live.push_back(i);
        end
      end

      beat = '{kind: KindVerdict, verdict: verdict, slot: 4'd0, value: 12'd0,
               last: (live.size() == 0)};
      pending_q.push_back(beat);
      n_planned++;
      foreach (live[k]) begin
        w = chan_word(live[k]);
        beat.kind    = KindChannel;
        beat.verdict = VerdictAccept;
        beat.slot    = 4'(live[k]) + (w[11] ? 4'd8 : 4'd0);
        beat.value   = {1'b0, w[10:0]} - ValueOffset;
        beat.last    = (k == live.size() - 1);
        pending_q.push_back(beat);
        n_planned++;
        n_updates++;
      end
      clear_frame();
    endfunction

    // Compare one accepted output beat with the oldest queued one.
    function void check_result(result_beat_t got);
      result_beat_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("unexpected beat: kind %0d verdict %0d slot %0d value %0d last %0d",
                   got.kind, got.verdict, got.slot, $signed(got.value), got.last);
        return;
      end
      want = pending_q.pop_front();
      if (got.kind !== want.kind || got.verdict !== want.verdict || got.slot !== want.slot ||
          got.value !== want.value || got.last !== want.last) begin
        errors++;
        if (errors <= MaxReports)
          $display("mismatch: want kind %0d verdict %0d slot %0d value %0d last %0d, got %0d %0d %0d %0d %0d",
                   want.kind, want.verdict, want.slot, $signed(want.value), want.last,
                   got.kind, got.verdict, got.slot, $signed(got.value), got.last);
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = 2'd0;
  logic [15:0] cfg_data_i    = 16'h0000;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] frame_byte
  logic [0:0]  s_axis_tuser  = 1'b0;    // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;            // [1:0] verdict, [5:2] slot, [17:6] value
  logic [0:0]  m_axis_tuser;            // [0] result_kind
  logic        m_axis_tlast;

  frame_scoreboard sb;
  logic        cur_mode = 1'b0;
  logic [15:0] cur_id   = 16'h0000;
  logic [7:0]  cur_rx   = 8'h00;
  bit          gaps_on  = 1'b0;
  bit          stall_req = 1'b0;
  int          bytes_sent;
  int          idle_cycles;

  rc_frame_check_channel_unpack_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 50 MHz clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Monitor: every beat that completes a handshake goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) sb.note_frame_byte(s_axis_tdata, s_axis_tuser[0]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result('{kind: m_axis_tuser[0], verdict: m_axis_tdata[1:0],
                          slot: m_axis_tdata[5:2], value: m_axis_tdata[17:6],
                          last: m_axis_tlast});
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Random gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result receiver: random back-pressure plus a long hold on request.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongStall) @(posedge clk_i);
        stall_req = 1'b0;
      end else begin
        if (hold == 0) hold = pick_gap();
        else hold--;
        m_axis_tready <= (hold == 0);
      end
    end
  end

  // Offer one frame byte and wait for its beat to be taken.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Stop offering bytes and wait until all predicted beats are out.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Register write, only with the block idle.
  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgLongMode: cur_mode = data[0];
      CfgBoundId:  cur_id   = data;
      CfgBoundRx:  cur_rx   = data[7:0];
      default: ;
    endcase
  endtask

  // Build a frame for the current settings, spoil it as asked and send the
  // first cut bytes (all of them when cut is 0). Negative fill or flag means random.
  task automatic send_frame(input frame_fault_e fault, input bit with_start, input int cut,
                            input int fill, input int flag_val);
    logic [7:0]   fb [35];
    logic [15:0]  crc;
    int           flen;
    int           n;
    int           count;
    frame_fault_e f;
    flen = cur_mode ? 35 : 32;
    f = fault;
    if (f == FaultRx && cur_rx == 8'h00) f = FaultId;
    for (n = 0; n < flen; n++) fb[n] = 8'($urandom_range(0, 255));

    if (f != FaultJunk) begin
      fb[0] = 8'(flen - 3);
      fb[1] = cur_id[15:8];
      fb[2] = cur_id[7:0];
      case ($urandom_range(0, 2))
        0: fb[6] = 8'h00;
        1: fb[6] = cur_rx;
        default: if (cur_rx != 8'h00) fb[6] = cur_rx;
      endcase
      if (flag_val >= 0) fb[7] = 8'(flag_val);
      else if ($urandom_range(0, 3) == 0) fb[7] = SkipBase + 8'(2 * $urandom_range(0, Words - 1));
      if (fill >= 0) for (n = 9; n <= 20; n++) fb[n] = 8'(fill);

      // Header faults go in before the checksum is computed.
      case (f)
        FaultLen: fb[0] = fb[0] ^ 8'($urandom_range(1, 255));
        FaultId, FaultBoth: begin
          n = 1 + $urandom_range(0, 1);
          fb[n] = fb[n] ^ (8'h01 << $urandom_range(0, 7));
        end
        FaultRx: begin
          do fb[6] = 8'($urandom_range(1, 255)); while (fb[6] == cur_rx);
        end
        default: ;
      endcase

      crc = 16'h0000;
      for (n = 3; n <= flen - 5; n++) crc = sb.crc_step(crc, fb[n]);
      fb[flen - 4] = crc[15:8];
      fb[flen - 3] = crc[7:0];

      // A single flipped bit in the covered bytes or the stored checksum.
      if (f == FaultCrc || f == FaultBoth) begin
        n = $urandom_range(3, flen - 3);
        fb[n] = fb[n] ^ (8'h01 << $urandom_range(0, 7));
      end
    end

    count = (cut == 0 || cut > flen) ? flen : cut;
    for (n = 0; n < count; n++) send_byte(fb[n], (n == 0) && with_start);
  endtask

  initial begin
    int               directed_bytes;
    int               directed_planned;
    int               phase;
    int               nwrites;
    int               idx;
    logic [15:0]      data;
    frame_fault_e     fault;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames at the reset settings: first byte without a start flag,
    // channel extremes, skipped first and last words, restart mid-frame.
    send_frame(FaultNone, 1'b0, 0, 8'hFF, 8'h11);
    send_frame(FaultNone, 1'b0, 0, 8'h00, SkipBase);
    send_frame(FaultNone, 1'b1, 10, -1, -1);
    send_frame(FaultNone, 1'b1, 0, -1, SkipBase + 8'd14);
    send_frame(FaultCrc, 1'b1, 0, -1, -1);
    send_frame(FaultLen, 1'b1, 0, -1, -1);
    send_frame(FaultId, 1'b1, 0, -1, -1);
    send_frame(FaultBoth, 1'b1, 0, -1, -1);

    // Long frames with extreme bindings, then a mode change mid-frame.
    write_cfg(CfgBoundRx, 16'hA5FF);
    write_cfg(CfgBoundId, 16'hFFFF);
    write_cfg(CfgLongMode, 16'h5A01);
    send_frame(FaultNone, 1'b1, 0, -1, -1);
    send_frame(FaultRx, 1'b1, 0, -1, -1);
    send_frame(FaultNone, 1'b1, 33, -1, -1);
    write_cfg(CfgLongMode, 16'hFFFE);
    send_frame(FaultNone, 1'b0, 0, -1, -1);
    write_cfg(CfgBoundId, 16'h0000);
    directed_bytes   = bytes_sent;
    directed_planned = sb.n_planned;

    // Random phases: new settings, then a few mostly well-formed frames.
    phase = 0;
    while (bytes_sent - directed_bytes < ItemTarget ||
           sb.n_planned - directed_planned < ResultTarget) begin
      if (phase > 0) begin
        nwrites = $urandom_range(1, 3);
        repeat (nwrites) begin
          idx = $urandom_range(0, 2);
          data = 16'($urandom_range(0, 65535));
          case (2'(idx))
            CfgBoundId: begin
              if ($urandom_range(0, 3) == 0) data = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            CfgBoundRx: begin
              if ($urandom_range(0, 2) == 0) data[7:0] = 8'h00;
              else if ($urandom_range(0, 3) == 0) data[7:0] = 8'hFF;
            end
            default: ;
          endcase
          write_cfg(2'(idx), data);
        end
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      if (phase == 1 || $urandom_range(0, 9) == 0) begin
        stall_req = 1'b1;
        gaps_on = 1'b0;
      end
      repeat (3) begin
        fault = ($urandom_range(0, 99) < 60) ? FaultNone : frame_fault_e'($urandom_range(1, 6));
        send_frame(fault, $urandom_range(0, 4) != 0,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(1, 34) : 0, -1, -1);
      end
      phase++;
    end

    // Drain and settle.
    wait_idle();
    if (sb.pending_q.size() != 0) begin
      sb.errors++;
      $display("%0d predicted beats never arrived", sb.pending_q.size());
    end
    $display("Sent %0d bytes forming %0d frames: %0d accepted, %0d checksum rejects, %0d header rejects.",
             bytes_sent, sb.n_frames, sb.n_accept, sb.n_crc_bad, sb.n_hdr_bad);
    $display("Checked %0d channel updates over %0d register writes; %0d errors.",
             sb.n_updates, sb.n_writes, sb.errors);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
